>>> hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of aclk, ignored while the block is in reset.
`define CHECK_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Checked on every rising edge of aclk, reset included.
`define CHECK_ANY_TIME(name, prop, msg) \
    name: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

>>> hw/rtl/firdc_pkg.sv
package firdc_pkg;

    // Field widths of the sample and coefficient paths.
    localparam int SAMPLE_W   = 32;
    localparam int COEF_W     = 16;
    // A scaled coefficient can reach twice the raw range.
    localparam int SCOEF_W    = COEF_W + 2;
    localparam int NUM_COEF   = 8;
    localparam int CFG_IDX_W  = 3;
    // At this fraction width or above every scaled coefficient is zero.
    localparam int FRAC_LIMIT = 20;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [COEF_W-1:0]   coef_t;
    typedef logic signed [SCOEF_W-1:0]  scoef_t;

endpackage

>>> hw/rtl/fir_filter_delay_compensated.sv
// Each accepted sample beat is held in the input skid register and its result is
// then registered in the output register; an output stall can come between them.
// Throughput: one sample per cycle while the output is not stalled; a beat with
// block_end is followed by padding, in which the single filter datapath runs the
// held sample and takes no input. Reset: aresetn is synchronous, active low, and
// clears the coefficients, delay line, block position and both handshake stages.
`include "assert_macros.svh"

module fir_filter_delay_compensated
    import firdc_pkg::*;
#(
    parameter int TAP_ORDER     = 7,
    parameter int FRACTION_BITS = 15,
    parameter int BLOCK_MAX     = 512
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Configuration write port
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COEF_W-1:0]    cfg_data,
    // Sample input
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [SAMPLE_W-1:0]  s_sample,
    input  logic                 s_block_end,
    // Filtered output
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [SAMPLE_W-1:0]  m_filtered,
    output logic                 m_last_of_block
);

    localparam int PAD_COUNT = TAP_ORDER / 2 + 1;
    localparam int PAD_W     = $clog2(PAD_COUNT + 1);
    localparam int BP_W      = $clog2(BLOCK_MAX);
    localparam int BP_LIMIT  = BLOCK_MAX - PAD_COUNT;
    localparam int PROD_W    = SAMPLE_W + SCOEF_W;

    // Reciprocal of 2^F-1, exact for every 16-bit magnitude.
    localparam int          RECIP_SHIFT = COEF_W + FRACTION_BITS;
    localparam logic [63:0] DIVISOR     = (64'd1 << FRACTION_BITS) - 64'd1;
    localparam logic [63:0] RECIP       = ((64'd1 << RECIP_SHIFT) + DIVISOR - 64'd1) / DIVISOR;
    localparam int          RECIP_W     = COEF_W + 2;

    // ------------------------------------------------------------------
    // Coefficient scaling on write: raw * 2^F / (2^F-1) = raw + raw/(2^F-1).
    // ------------------------------------------------------------------
    coef_t                       cfg_raw;
    logic                        cfg_neg;
    logic [COEF_W:0]             cfg_mag;
    logic [COEF_W+RECIP_W-1:0]   cfg_prod;
    logic [COEF_W-1:0]           cfg_quot;
    scoef_t                      cfg_corr;
    scoef_t                      cfg_scaled;

    always_comb begin
        cfg_raw  = coef_t'(cfg_data);
        cfg_neg  = cfg_raw[COEF_W-1];
        cfg_mag  = cfg_neg ? ((COEF_W+1)'(0) - {cfg_raw[COEF_W-1], cfg_raw})
                           : {cfg_raw[COEF_W-1], cfg_raw};
        cfg_prod = cfg_mag[COEF_W-1:0] * RECIP[RECIP_W-1:0];
        cfg_quot = COEF_W'(cfg_prod >> RECIP_SHIFT);
        cfg_corr = cfg_neg ? (SCOEF_W'(0) - SCOEF_W'(cfg_quot)) : SCOEF_W'(cfg_quot);
        if (FRACTION_BITS >= FRAC_LIMIT) begin
            cfg_scaled = '0;
        end else begin
            cfg_scaled = SCOEF_W'(cfg_raw) + cfg_corr;
        end
    end

    scoef_t coef_reg [NUM_COEF];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_COEF; i++) begin
                coef_reg[i] <= '0;
            end
        end else if (cfg_wr_en) begin
            coef_reg[cfg_index] <= cfg_scaled;
        end
    end

    // ------------------------------------------------------------------
    // Control and datapath signals.
    // ------------------------------------------------------------------
    logic                 in_valid_reg, in_valid_next;
    sample_t              in_sample_reg;
    logic                 in_end_reg;
    logic [PAD_W-1:0]     pad_left_reg, pad_left_next;
    logic [BP_W-1:0]      bp_reg, bp_next;
    sample_t              held_reg, held_next;
    sample_t              dline_reg [TAP_ORDER];
    logic                 m_valid_reg, m_valid_next;
    sample_t              m_filtered_reg;
    logic                 m_last_reg;

    logic                 can_adv;
    logic                 padding;
    logic                 in_take;
    logic                 run_in;
    logic                 run_pad;
    logic                 run;
    logic                 emit;
    logic                 last_pad;
    sample_t              filt_x;
    logic [SAMPLE_W-1:0]  terms [TAP_ORDER+1];
    logic [SAMPLE_W-1:0]  acc;

    // The engine advances whenever the output register is free or being taken.
    always_comb begin
        can_adv  = !m_valid_reg || m_ready;
        padding  = (pad_left_reg != '0);
        in_take  = can_adv && !padding && in_valid_reg;
        run_in   = in_take && (bp_reg < BP_W'(BP_LIMIT));
        run_pad  = can_adv && padding;
        run      = run_in || run_pad;
        last_pad = run_pad && (pad_left_reg == PAD_W'(1));
        filt_x   = padding ? held_reg : in_sample_reg;
        if (run_in) begin
            emit = (bp_reg >= BP_W'(PAD_COUNT));
        end else if (run_pad) begin
            emit = (bp_reg >= BP_W'(pad_left_reg));
        end else begin
            emit = 1'b0;
        end
    end

    assign s_ready = !in_valid_reg || in_take;

    // One product per tap, floor-shifted by the fraction width, then summed mod 2^32.
    always_comb begin
        logic signed [PROD_W-1:0] prod;
        logic signed [PROD_W-1:0] shifted;
        sample_t                  x;
        for (int j = 0; j <= TAP_ORDER; j++) begin
            x       = (j == 0) ? filt_x : dline_reg[(j == 0) ? 0 : j - 1];
            prod    = x * coef_reg[j];
            shifted = prod >>> FRACTION_BITS;
            terms[j] = shifted[SAMPLE_W-1:0];
        end
        acc = '0;
        for (int j = 0; j <= TAP_ORDER; j++) begin
            acc = acc + terms[j];
        end
    end

    // Next-state logic for the skid register, padding count, block position, held sample and output valid.
    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (in_take) begin
            in_valid_next = 1'b0;
        end

        pad_left_next = pad_left_reg;
        if (run_pad) begin
            pad_left_next = pad_left_reg - PAD_W'(1);
        end else if (in_take && in_end_reg) begin
            pad_left_next = PAD_W'(PAD_COUNT);
        end

        bp_next = bp_reg;
        if (last_pad) begin
            bp_next = '0;
        end else if (run_in) begin
            bp_next = bp_reg + BP_W'(1);
        end

        held_next = run_in ? in_sample_reg : held_reg;

        m_valid_next = m_valid_reg;
        if (can_adv) begin
            m_valid_next = run && emit;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            pad_left_reg <= '0;
            bp_reg       <= '0;
            held_reg     <= '0;
            m_valid_reg  <= 1'b0;
            for (int i = 0; i < TAP_ORDER; i++) begin
                dline_reg[i] <= '0;
            end
        end else begin
            in_valid_reg <= in_valid_next;
            pad_left_reg <= pad_left_next;
            bp_reg       <= bp_next;
            held_reg     <= held_next;
            m_valid_reg  <= m_valid_next;
            if (run) begin
                dline_reg[0] <= filt_x;
                for (int i = 1; i < TAP_ORDER; i++) begin
                    dline_reg[i] <= dline_reg[i-1];
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_sample_reg <= sample_t'(s_sample);
            in_end_reg    <= s_block_end;
        end
        if (run && emit) begin
            m_filtered_reg <= sample_t'(acc);
            m_last_reg     <= last_pad;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_filtered      = m_filtered_reg;
    assign m_last_of_block = m_last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `CHECK_ALWAYS(a_pad_bound, pad_left_reg <= PAD_W'(PAD_COUNT), "padding count out of range")
    `CHECK_ALWAYS(a_bp_bound, bp_reg <= BP_W'(BP_LIMIT), "block position past its limit")
    `CHECK_ALWAYS(a_last_closes, (m_valid_reg && m_last_reg) |-> (bp_reg == '0), "last beat without block close")
    `CHECK_ALWAYS(a_no_take_in_pad, padding |-> !in_take, "input taken during padding")

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;
    import firdc_pkg::*;

    localparam int TAP_ORDER     = 7;
    localparam int FRACTION_BITS = 15;
    localparam int BLOCK_MAX     = 512;
    // Outputs dropped at the head of a block, and padding beats at its end.
    localparam int PAD_COUNT     = TAP_ORDER / 2 + 1;
    // Cycles to let pass after the last expected result before the next stimulus.
    localparam int DRAIN_CYCLES  = 12;
    localparam longint TIMEOUT_NS = 64'd10_000_000;

    localparam sample_t SAMPLE_MAX = 32'sh7FFF_FFFF;
    localparam sample_t SAMPLE_MIN = 32'sh8000_0000;
    localparam coef_t   COEF_MAX   = 16'sh7FFF;
    localparam coef_t   COEF_MIN   = 16'sh8000;

    typedef struct {
        sample_t filtered;
        logic    last;
    } fir_out_t;

    // Tracks the filter state and the queue of outputs still owed by the block.
    class fir_scoreboard;
        coef_t       coef [NUM_COEF];
        sample_t     taps [TAP_ORDER];
        int unsigned wr_ptr;
        int unsigned blk_pos;
        sample_t     held;
        fir_out_t    owed_q [$];
        int unsigned n_errors;

        function new();
            foreach (coef[k]) coef[k] = '0;
            foreach (taps[k]) taps[k] = '0;
            wr_ptr   = 0;
            blk_pos  = 0;
            held     = '0;
            n_errors = 0;
        endfunction

        function void set_coef(int idx, coef_t v);
            coef[idx] = v;
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        // Raw coefficient scaled to the Q format, truncated toward zero.
        function longint scaled(int k);
            longint raw;
            longint one;
            raw = longint'(coef[k]);
            one = longint'(1) << FRACTION_BITS;
            if (FRACTION_BITS >= FRAC_LIMIT)
                return 0;
            return (raw * one) / (one - 1);
        endfunction

        // Runs one sample through the taps and advances the delay line.
        function sample_t shift_in(sample_t x);
            logic [SAMPLE_W-1:0] acc;
            longint              prod;
            sample_t             v;
            acc = '0;
            for (int j = 0; j <= TAP_ORDER; j++) begin
                v = (j == 0) ? x : taps[(wr_ptr + TAP_ORDER - j) % TAP_ORDER];
                prod = scaled(j) * longint'(v);
                acc = acc + SAMPLE_W'(prod >>> FRACTION_BITS);
            end
            taps[wr_ptr] = x;
            wr_ptr = (wr_ptr + 1) % TAP_ORDER;
            return sample_t'(acc);
        endfunction

        // Called for each accepted input beat; queues the outputs it produces.
        function void note_beat(sample_t x, logic bend);
            sample_t  y;
            fir_out_t r;
            if (blk_pos < BLOCK_MAX - PAD_COUNT) begin
                y = shift_in(x);
                held = x;
                if (blk_pos >= PAD_COUNT) begin
                    r.filtered = y;
                    r.last = 1'b0;
                    owed_q.push_back(r);
                end
                blk_pos++;
            end
            if (bend) begin
                for (int i = 0; i < PAD_COUNT; i++) begin
                    y = shift_in(held);
                    if (blk_pos + i >= PAD_COUNT) begin
                        r.filtered = y;
                        r.last = (i == PAD_COUNT - 1);
                        owed_q.push_back(r);
                    end
                end
                blk_pos = 0;
            end
        endfunction

        function void check_result(sample_t y, logic last);
            fir_out_t r;
            if (owed_q.size() == 0) begin
                $display("%0t: output beat with nothing expected: filtered %h last %b",
                         $time, y, last);
                n_errors++;
                return;
            end
            r = owed_q.pop_front();
            if (y !== r.filtered) begin
                $display("%0t: filtered mismatch: expected %h, actual %h",
                         $time, r.filtered, y);
                n_errors++;
            end
            if (last !== r.last) begin
                $display("%0t: last_of_block mismatch: expected %b, actual %b",
                         $time, r.last, last);
                n_errors++;
            end
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [COEF_W-1:0]    cfg_data;
    logic                 s_valid;
    logic                 s_ready;
    logic [SAMPLE_W-1:0]  s_sample;
    logic                 s_block_end;
    logic                 m_valid;
    logic                 m_ready;
    logic [SAMPLE_W-1:0]  m_filtered;
    logic                 m_last_of_block;

    fir_scoreboard sb = new();
    // Percent chance of an idle burst before a beat, per side; zero means none.
    int tx_idle_odds = 25;
    int rx_idle_odds = 25;

    fir_filter_delay_compensated #(
        .TAP_ORDER    (TAP_ORDER),
        .FRACTION_BITS(FRACTION_BITS),
        .BLOCK_MAX    (BLOCK_MAX)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample       (s_sample),
        .s_block_end    (s_block_end),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_filtered     (m_filtered),
        .m_last_of_block(m_last_of_block)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("simulation failed");
        $finish;
    end

    // Output side: ready drops in random bursts.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (aresetn && rx_idle_odds != 0 && $urandom_range(1, 100) <= rx_idle_odds) begin
                m_ready = 1'b0;
                repeat ($urandom_range(1, 15) - 1) @(negedge aclk);
            end else begin
                m_ready = aresetn;
            end
        end
    end

    // Every output beat is checked against the oldest expected one.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_filtered, m_last_of_block);
    end

    task automatic write_coef(int idx, coef_t v);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_index = CFG_IDX_W'(idx);
        cfg_data  = v;
        @(posedge aclk);
        sb.set_coef(idx, v);
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic send_beat(sample_t x, logic bend);
        @(negedge aclk);
        s_valid     = 1'b1;
        s_sample    = x;
        s_block_end = bend;
        do @(posedge aclk); while (!s_ready);
        sb.note_beat(x, bend);
    endtask

    task automatic hold_off(int n);
        @(negedge aclk);
        s_valid = 1'b0;
        repeat (n) @(posedge aclk);
    endtask

    // Stops sending until every owed output is out, then lets the pipeline settle.
    task automatic drain();
        @(negedge aclk);
        s_valid = 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic sample_t pick_sample();
        case ($urandom_range(0, 9))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2:       return '0;
            3:       return -1;
            default: return sample_t'($urandom);
        endcase
    endfunction

    // Random blocks, mostly short, now and then a longer one.
    task automatic run_blocks(int n_items, int max_len);
        int sent;
        int len;
        sent = 0;
        while (sent < n_items) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, max_len)
                                              : $urandom_range(1, 12);
            for (int i = 0; i < len; i++) begin
                if (tx_idle_odds != 0 && $urandom_range(1, 100) <= tx_idle_odds)
                    hold_off($urandom_range(1, 15));
                send_beat(pick_sample(), i == len - 1);
            end
            sent += len;
        end
    endtask

    task automatic load_all(coef_t v);
        for (int k = 0; k < NUM_COEF; k++)
            write_coef(k, v);
    endtask

    task automatic load_random();
        for (int k = 0; k < NUM_COEF; k++)
            write_coef(k, coef_t'($urandom));
    endtask

    initial begin
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        s_valid     = 1'b0;
        s_sample    = '0;
        s_block_end = 1'b0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        repeat (4) @(posedge aclk);

        // Mixed extremes across the taps.
        write_coef(0, COEF_MAX);
        write_coef(1, COEF_MIN);
        write_coef(2, 16'sd1);
        write_coef(3, -16'sd1);
        write_coef(4, 16'sh4000);
        write_coef(5, -16'sh4000);
        write_coef(6, 16'sd12345);
        write_coef(7, -16'sd321);

        // Short blocks: only the flagged padding output survives a one-beat block.
        send_beat(SAMPLE_MAX, 1'b1);
        send_beat(SAMPLE_MIN, 1'b0);
        send_beat(-1, 1'b1);
        send_beat('0, 1'b0);
        send_beat(32'sd1, 1'b0);
        send_beat(-1, 1'b0);
        send_beat(SAMPLE_MAX, 1'b0);
        send_beat(SAMPLE_MIN, 1'b1);
        // A longer block with a full pause in the middle.
        send_beat(SAMPLE_MAX, 1'b0);
        send_beat(SAMPLE_MAX, 1'b0);
        send_beat(SAMPLE_MIN, 1'b0);
        drain();
        send_beat(SAMPLE_MIN, 1'b0);
        send_beat(32'sh5555_5555, 1'b0);
        send_beat(32'shAAAA_AAAA, 1'b0);
        send_beat('0, 1'b0);
        send_beat(-1, 1'b1);
        drain();

        load_all(COEF_MAX);
        run_blocks(40, 30);
        drain();

        load_all(COEF_MIN);
        rx_idle_odds = 0;
        run_blocks(40, 30);
        drain();

        load_random();
        rx_idle_odds = 25;
        tx_idle_odds = 30;
        run_blocks(45, 40);
        drain();

        // Closing stretch with both sides running flat out.
        write_coef(0, 16'sh0000);
        load_random();
        tx_idle_odds = 0;
        rx_idle_odds = 0;
        run_blocks(50, 25);
        drain();

        if (sb.n_errors == 0 && sb.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
